[rtl/stwc_pkg.sv]
// Package for the shock-triggered window capture block.
// Holds the sizing constants, the stored sample type, register indexes and state types.
// Depends on nothing; every other file in rtl imports it.
package stwc_pkg;

    // Depth of the capture window and width of one stored feature.
    localparam int WINDOW       = 64;
    localparam int FEAT_BITS    = 16;

    // Fixed widths of the ports.
    localparam int IO_BITS       = 16;
    localparam int MAG_BITS      = 16;
    localparam int CNT_BITS      = 8;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // Counter wide enough to hold WINDOW itself.
    localparam int WIN_CNT_BITS = $clog2(WINDOW + 1);

    // Reset values of the configuration registers.
    localparam logic [MAG_BITS-1:0] HIGH_THR_RESET = MAG_BITS'(512);   // 2.0 g in Q8.8
    localparam logic [MAG_BITS-1:0] LOW_THR_RESET  = MAG_BITS'(154);   // 0.6 g in Q8.8
    localparam logic [CNT_BITS-1:0] POST_RESET     = CNT_BITS'(50);
    localparam logic [CNT_BITS-1:0] COOL_RESET     = CNT_BITS'(50);

    typedef logic [FEAT_BITS-1:0] feat_t;

    typedef struct packed {
        feat_t pitch;
        feat_t roll;
        feat_t magnitude;
        feat_t gyro_x;
        feat_t gyro_y;
        feat_t gyro_z;
    } entry_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_HIGH_THR = 2'd0,
        CFG_LOW_THR  = 2'd1,
        CFG_POST     = 2'd2,
        CFG_COOL     = 2'd3
    } cfg_addr_t;

    typedef enum logic {
        TRG_IDLE    = 1'b0,
        TRG_CAPTURE = 1'b1
    } trg_state_t;

    typedef enum logic {
        RD_IDLE = 1'b0,
        RD_DUMP = 1'b1
    } rd_state_t;

endpackage

[rtl/stwc_cell.sv]
// One cell of the sample chain: holds a single stored sample.
// Loads from its neighbour whenever the chain moves. Depends on stwc_pkg.
module stwc_cell (
    input  logic            aclk,
    input  logic            shift_en,
    input  stwc_pkg::entry_t d_in,
    output stwc_pkg::entry_t q_out
);
    import stwc_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= d_in;
        end
    end

    assign q_out = entry_reg;

endmodule

[rtl/stwc_trigger.sv]
// Trigger machine, fill count and configuration registers of the capture block.
// Decides, per accepted sample, whether a window dump starts. Depends on stwc_pkg.
module stwc_trigger (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [stwc_pkg::MAG_BITS-1:0]       magnitude,
    input  logic                                cfg_we,
    input  logic [stwc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [stwc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output logic                                start_dump
);
    import stwc_pkg::*;

    trg_state_t              state_reg, state_next;
    logic [CNT_BITS-1:0]     post_reg, post_next;
    logic [CNT_BITS-1:0]     cool_reg, cool_next;
    logic [WIN_CNT_BITS-1:0] fill_reg, fill_next;
    logic [MAG_BITS-1:0]     high_thr_reg, low_thr_reg;
    logic [CNT_BITS-1:0]     post_load_reg, cool_load_reg;

    logic                    hit;
    logic                    capture_end;
    logic [CNT_BITS-1:0]     cool_mid;

    assign hit = (magnitude > high_thr_reg) || (magnitude < low_thr_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        if (accept) begin
            unique case (state_reg)
                TRG_IDLE: begin
                    if (cool_reg == '0 && hit) begin
                        state_next = TRG_CAPTURE;
                    end
                end
                TRG_CAPTURE: begin
                    if (post_reg == '0) begin
                        state_next = TRG_IDLE;
                    end
                end
                default: state_next = TRG_IDLE;
            endcase
        end
    end

    // Counters and the dump request.
    always_comb begin
        fill_next   = fill_reg;
        post_next   = post_reg;
        cool_next   = cool_reg;
        capture_end = 1'b0;
        cool_mid    = cool_reg;
        start_dump  = 1'b0;
        if (accept) begin
            // The sample is stored before the machine looks at the fill level.
            if (fill_reg != WIN_CNT_BITS'(WINDOW)) begin
                fill_next = fill_reg + WIN_CNT_BITS'(1);
            end
            unique case (state_reg)
                TRG_IDLE: begin
                    if (cool_reg == '0 && hit) begin
                        post_next = post_load_reg;
                    end
                end
                TRG_CAPTURE: begin
                    if (post_reg != '0) begin
                        post_next = post_reg - CNT_BITS'(1);
                    end else begin
                        capture_end = 1'b1;
                    end
                end
                default: post_next = post_reg;
            endcase
            if (capture_end) begin
                cool_mid   = cool_load_reg;
                start_dump = (fill_next == WIN_CNT_BITS'(WINDOW));
            end
            // The cooldown also counts down in the step that loads it.
            cool_next = (cool_mid != '0) ? cool_mid - CNT_BITS'(1) : cool_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TRG_IDLE;
            post_reg  <= '0;
            cool_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            post_reg  <= post_next;
            cool_reg  <= cool_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg  <= HIGH_THR_RESET;
            low_thr_reg   <= LOW_THR_RESET;
            post_load_reg <= POST_RESET;
            cool_load_reg <= COOL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_HIGH_THR: high_thr_reg  <= cfg_wdata[MAG_BITS-1:0];
                CFG_LOW_THR:  low_thr_reg   <= cfg_wdata[MAG_BITS-1:0];
                CFG_POST:     post_load_reg <= cfg_wdata[CNT_BITS-1:0];
                CFG_COOL:     cool_load_reg <= cfg_wdata[CNT_BITS-1:0];
                default:      high_thr_reg  <= high_thr_reg;
            endcase
        end
    end

    // The countdown is only ever nonzero while a capture is running.
    a_post_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == TRG_IDLE |-> post_reg == '0)
        else $error("post-trigger countdown nonzero outside a capture");

endmodule

[rtl/stwc_readout.sv]
// Dump sequencer and output register of the capture block.
// Rotates the sample chain once round, presenting its tail oldest-first. Depends on stwc_pkg.
module stwc_readout (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start_dump,
    input  stwc_pkg::entry_t    tail,
    input  logic                m_ready,
    output logic                rotate,
    output logic                in_ready,
    output logic                m_valid,
    output stwc_pkg::entry_t    out_entry,
    output logic                m_last
);
    import stwc_pkg::*;

    rd_state_t               state_reg, state_next;
    logic [WIN_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    valid_reg, valid_next;
    entry_t                  data_reg;
    logic                    last_reg;
    logic                    slot_free;
    logic                    is_last;

    assign slot_free = !valid_reg || m_ready;
    assign is_last   = (cnt_reg == WIN_CNT_BITS'(1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            RD_IDLE: begin
                if (start_dump) begin
                    state_next = RD_DUMP;
                end
            end
            RD_DUMP: begin
                if (slot_free && is_last) begin
                    state_next = RD_IDLE;
                end
            end
            default: state_next = RD_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        rotate     = 1'b0;
        in_ready   = 1'b0;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_ready;
        unique case (state_reg)
            RD_IDLE: begin
                in_ready = 1'b1;
                if (start_dump) begin
                    cnt_next = WIN_CNT_BITS'(WINDOW);
                end
            end
            RD_DUMP: begin
                if (slot_free) begin
                    rotate     = 1'b1;
                    valid_next = 1'b1;
                    cnt_next   = cnt_reg - WIN_CNT_BITS'(1);
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RD_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rotate) begin
            data_reg <= tail;
            last_reg <= is_last;
        end
    end

    assign m_valid   = valid_reg;
    assign out_entry = data_reg;
    assign m_last    = last_reg;

    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start_dump |-> state_reg == RD_IDLE)
        else $error("dump requested while a dump is running");

    a_dump_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == RD_DUMP |-> cnt_reg != '0)
        else $error("dump running with no entries left");

    a_last_ends_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RD_DUMP && rotate && is_last) |=> (state_reg == RD_IDLE && last_reg))
        else $error("dump did not end on its last entry");

endmodule

[rtl/shock_triggered_window_capture.sv]
// Top level of the shock-triggered window capture block.
// Instantiates the sample chain cells, the trigger machine and the readout. Depends on stwc_pkg.
//
//  Channel   Direction  Handshake            Contents
//  s_        in         s_valid / s_ready    one six-feature motion sample
//  m_        out        m_valid / m_ready    one stored sample of a dump, with m_last_entry
//  cfg_      in         cfg_we               register write, index cfg_addr, data cfg_wdata
//
// Outside a dump one sample transfer is taken every clock cycle.
// A dump holds s_ready low while all WINDOW (64) stored samples are read out: the chain
// has a single read point at its tail, so one sample leaves per cycle unless m_ready stalls.
// Reset is synchronous on aresetn and clears the control state; the chain contents are
// left as they are and are never read before the window has been filled.
// The output register lets the last entry of a dump wait for m_ready while new samples
// are already taken.
module shock_triggered_window_capture (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [stwc_pkg::IO_BITS-1:0] s_pitch_in,
    input  logic signed [stwc_pkg::IO_BITS-1:0] s_roll_in,
    input  logic        [stwc_pkg::IO_BITS-1:0] s_magnitude_in,
    input  logic signed [stwc_pkg::IO_BITS-1:0] s_gyro_x_in,
    input  logic signed [stwc_pkg::IO_BITS-1:0] s_gyro_y_in,
    input  logic signed [stwc_pkg::IO_BITS-1:0] s_gyro_z_in,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [stwc_pkg::IO_BITS-1:0] m_pitch_out,
    output logic signed [stwc_pkg::IO_BITS-1:0] m_roll_out,
    output logic        [stwc_pkg::IO_BITS-1:0] m_magnitude_out,
    output logic signed [stwc_pkg::IO_BITS-1:0] m_gyro_x_out,
    output logic signed [stwc_pkg::IO_BITS-1:0] m_gyro_y_out,
    output logic signed [stwc_pkg::IO_BITS-1:0] m_gyro_z_out,
    output logic                                m_last_entry,

    input  logic                                cfg_we,
    input  logic [stwc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [stwc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import stwc_pkg::*;

    logic   s_accept;
    logic   start_dump;
    logic   rotate;
    logic   shift_en;
    entry_t sample;
    entry_t head_d;
    entry_t out_entry;
    entry_t chain_q [WINDOW];

    assign s_accept = s_valid && s_ready;

    // Each feature keeps its low FEAT_BITS bits, as raw bits.
    assign sample.pitch     = FEAT_BITS'($unsigned(s_pitch_in));
    assign sample.roll      = FEAT_BITS'($unsigned(s_roll_in));
    assign sample.magnitude = FEAT_BITS'(s_magnitude_in);
    assign sample.gyro_x    = FEAT_BITS'($unsigned(s_gyro_x_in));
    assign sample.gyro_y    = FEAT_BITS'($unsigned(s_gyro_y_in));
    assign sample.gyro_z    = FEAT_BITS'($unsigned(s_gyro_z_in));

    // Cell 0 holds the newest sample and the last cell the oldest. A new sample pushes the
    // chain along by one; during a dump the tail is fed back into the head, so after
    // WINDOW rotations every cell holds what it held before the dump began.
    assign shift_en = s_accept || rotate;
    assign head_d   = rotate ? chain_q[WINDOW-1] : sample;

    for (genvar i = 0; i < WINDOW; i++) begin : g_chain
        if (i == 0) begin : g_head
            stwc_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (head_d),
                .q_out    (chain_q[i])
            );
        end else begin : g_body
            stwc_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (chain_q[i-1]),
                .q_out    (chain_q[i])
            );
        end
    end

    // Trigger machine: sees each accepted sample in the same cycle that it enters the chain.
    stwc_trigger u_trigger (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .magnitude  (s_magnitude_in),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .start_dump (start_dump)
    );

    // Readout: walks the chain once round and drives the result channel.
    stwc_readout u_readout (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_dump (start_dump),
        .tail       (chain_q[WINDOW-1]),
        .m_ready    (m_ready),
        .rotate     (rotate),
        .in_ready   (s_ready),
        .m_valid    (m_valid),
        .out_entry  (out_entry),
        .m_last     (m_last_entry)
    );

    assign m_pitch_out     = IO_BITS'(out_entry.pitch);
    assign m_roll_out      = IO_BITS'(out_entry.roll);
    assign m_magnitude_out = IO_BITS'(out_entry.magnitude);
    assign m_gyro_x_out    = IO_BITS'(out_entry.gyro_x);
    assign m_gyro_y_out    = IO_BITS'(out_entry.gyro_y);
    assign m_gyro_z_out    = IO_BITS'(out_entry.gyro_z);

endmodule
